// File: hw/rtl/sfce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfce_pkg
// Shared constants, codes and types for the symmetric FIR clamp-to-edge unit.
// ----------------------------------------------------------------------------
package sfce_pkg;

  localparam int MAX_SPAN    = 15;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_W      = 16;
  localparam int FRAC_BITS   = 15;

  localparam int WIN_DEPTH = 2 * MAX_SPAN + 1;
  localparam int CENTER    = MAX_SPAN;
  localparam int NTAPS     = MAX_SPAN + 1;
  localparam int CNT_W     = $clog2(NTAPS);
  localparam int SPAN_W    = 4;

  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int COEFS_PER_REG  = CFG_DATA_W / COEF_W;
  localparam int COEF_REGS      = 4;

  localparam int POS_MAX = 31;
  localparam int POS_W   = $clog2(POS_MAX + 1);

  localparam int PROD_W   = COEF_W + SAMPLE_BITS + 1;
  localparam int ACC_W    = SAMPLE_BITS + COEF_W + $clog2(WIN_DEPTH);
  localparam int SCALED_W = ACC_W - FRAC_BITS;

  localparam logic [ACC_W-1:0]       ROUND_HALF  = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX  = '1;
  localparam logic [CFG_DATA_W-1:0]  COEF0_RESET = CFG_DATA_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_SPAN   = 3'd0,
    REG_COEFS_0_3  = 3'd1,
    REG_COEFS_4_7  = 3'd2,
    REG_COEFS_8_11 = 3'd3,
    REG_COEFS_12_15 = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_EVAL,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic accept;
    logic line_start;
    logic shift_x;
    logic out_load;
    logic out_last;
  } ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/sfce_tap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfce_tap
// One tap cell: folds a sample pair, weights it and adds it to the partial
// sum handed over by the previous cell.
// ----------------------------------------------------------------------------
module sfce_tap (
  input  wire logic                            clk_i,
  input  wire logic [sfce_pkg::COEF_W-1:0]     coef_i,
  input  wire logic [sfce_pkg::SAMPLE_BITS-1:0] newer_i,
  input  wire logic [sfce_pkg::SAMPLE_BITS-1:0] older_i,
  input  wire logic [sfce_pkg::ACC_W-1:0]      acc_i,
  output logic      [sfce_pkg::ACC_W-1:0]      acc_o
);

  logic [sfce_pkg::SAMPLE_BITS:0]  pair;
  logic [sfce_pkg::PROD_W-1:0]     prod;
  logic [sfce_pkg::ACC_W-1:0]      acc_d, acc_q;

  always_comb begin
    pair  = {1'b0, newer_i} + {1'b0, older_i};
    prod  = sfce_pkg::PROD_W'(coef_i) * sfce_pkg::PROD_W'(pair);
    acc_d = acc_i + sfce_pkg::ACC_W'(prod);
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

// File: hw/rtl/sfce_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfce_ctrl
// Sequencer: line position, window alignment, tap chain settling and
// result handoff, including the flush run at line end.
// ----------------------------------------------------------------------------
module sfce_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_last_i,
  input  wire logic [sfce_pkg::SPAN_W-1:0]   span_i,
  input  wire logic                          out_free_i,
  output logic                               in_ready_o,
  output sfce_pkg::ctrl_t                    ctrl_o
);

  sfce_pkg::state_e state_d, state_q;
  logic [sfce_pkg::POS_W-1:0] pos_d, pos_q;
  logic [sfce_pkg::CNT_W-1:0] align_d, align_q;
  logic [sfce_pkg::CNT_W-1:0] eval_d, eval_q;
  logic [sfce_pkg::CNT_W-1:0] remain_d, remain_q;
  logic                       flush_d, flush_q;

  logic                       need_out;
  logic                       short_line;
  logic [sfce_pkg::CNT_W-1:0] center_age;
  logic [sfce_pkg::CNT_W-1:0] shift_amt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sfce_pkg::ST_IDLE;
      pos_q    <= '0;
      align_q  <= '0;
      eval_q   <= '0;
      remain_q <= '0;
      flush_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      align_q  <= align_d;
      eval_q   <= eval_d;
      remain_q <= remain_d;
      flush_q  <= flush_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    align_d  = align_q;
    eval_d   = eval_q;
    remain_d = remain_q;
    flush_d  = flush_q;
    ctrl_o   = '0;
    in_ready_o = 1'b0;

    short_line = pos_q < sfce_pkg::POS_W'(span_i);
    need_out   = in_last_i || !short_line;
    // flush starts at the oldest missing output; short lines clamp to pos
    center_age = (in_last_i && short_line) ? pos_q[sfce_pkg::CNT_W-1:0]
                                           : sfce_pkg::CNT_W'(span_i);
    shift_amt  = sfce_pkg::CNT_W'(sfce_pkg::CENTER) - center_age;

    unique case (state_q)
      sfce_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.accept     = 1'b1;
          ctrl_o.line_start = (pos_q == '0);
          if (in_last_i) begin
            pos_d = '0;
          end else if (pos_q != sfce_pkg::POS_W'(sfce_pkg::POS_MAX)) begin
            pos_d = pos_q + 1'b1;
          end
          if (need_out) begin
            remain_d = in_last_i ? center_age : '0;
            flush_d  = in_last_i;
            eval_d   = '0;
            align_d  = shift_amt;
            state_d  = (shift_amt != '0) ? sfce_pkg::ST_ALIGN : sfce_pkg::ST_EVAL;
          end
        end
      end
      sfce_pkg::ST_ALIGN: begin
        ctrl_o.shift_x = 1'b1;
        align_d = align_q - 1'b1;
        if (align_q == sfce_pkg::CNT_W'(1)) begin
          eval_d  = '0;
          state_d = sfce_pkg::ST_EVAL;
        end
      end
      sfce_pkg::ST_EVAL: begin
        // partial sum walks down the tap cell chain to the last cell
        eval_d = eval_q + 1'b1;
        if (eval_q == sfce_pkg::CNT_W'(sfce_pkg::NTAPS - 1)) begin
          state_d = sfce_pkg::ST_HOLD;
        end
      end
      sfce_pkg::ST_HOLD: begin
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_last = flush_q && (remain_q == '0);
          if (remain_q == '0) begin
            state_d = sfce_pkg::ST_IDLE;
          end else begin
            remain_d       = remain_q - 1'b1;
            ctrl_o.shift_x = 1'b1;
            eval_d         = '0;
            state_d        = sfce_pkg::ST_EVAL;
          end
        end
      end
      default: begin
        state_d = sfce_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/symmetric_fir_clamp_edge_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// symmetric_fir_clamp_edge_unit
// Symmetric FIR along a line with clamp-to-edge borders, one line sample per
// input beat, rounded and saturated Q8.8 results.
// ----------------------------------------------------------------------------
// A sample that completes no output leaves the input side open. A sample that
// gives outputs closes the input side after its beat, shifts the tap window
// 15 - c places older to align it on the oldest output due (c = centre age:
// tap_span, or the line position on a short line), then for each output the
// partial sum walks down the chain of 16 tap cells and is handed off to the
// output register, which waits while the output is stalled. A line-end flush
// gives c + 1 outputs. The output register lets the next sample in while the
// final result of a beat still waits. Configuration is taken in every cycle;
// write it only while s_axis_tready is high and no sample is in flight.
// Outputs of a line at its end come in order, with tlast on the last one.
// ----------------------------------------------------------------------------
module symmetric_fir_clamp_edge_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // cfg
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [sfce_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [sfce_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [sfce_pkg::SAMPLE_BITS-1:0]   s_axis_tdata,   // [15:0] sample
  input  wire logic                               s_axis_tlast,   // line_end
  // output stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic      [sfce_pkg::SAMPLE_BITS-1:0]   m_axis_tdata,   // [15:0] filtered
  output logic                                    m_axis_tlast    // line_last
);

  // configuration registers
  logic [sfce_pkg::SPAN_W-1:0]     tap_span_q;
  logic [sfce_pkg::CFG_DATA_W-1:0] coef_q [sfce_pkg::COEF_REGS];
  logic [sfce_pkg::SPAN_W-1:0]     span_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_span_q <= '0;
      coef_q[0]  <= sfce_pkg::COEF0_RESET;
      coef_q[1]  <= '0;
      coef_q[2]  <= '0;
      coef_q[3]  <= '0;
    end else if (cfg_valid_i) begin
      unique case (sfce_pkg::cfg_reg_e'(cfg_index_i))
        sfce_pkg::REG_TAP_SPAN:    tap_span_q <= cfg_data_i[sfce_pkg::SPAN_W-1:0];
        sfce_pkg::REG_COEFS_0_3:   coef_q[0]  <= cfg_data_i;
        sfce_pkg::REG_COEFS_4_7:   coef_q[1]  <= cfg_data_i;
        sfce_pkg::REG_COEFS_8_11:  coef_q[2]  <= cfg_data_i;
        sfce_pkg::REG_COEFS_12_15: coef_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign span_eff = (tap_span_q > sfce_pkg::SPAN_W'(sfce_pkg::MAX_SPAN))
                  ? sfce_pkg::SPAN_W'(sfce_pkg::MAX_SPAN) : tap_span_q;

  // sequencer
  sfce_pkg::ctrl_t ctrl;
  logic            out_free;
  logic            out_valid_q;

  assign out_free = !out_valid_q || m_axis_tready;

  sfce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .span_i     (span_eff),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  // sample window, newest at index 0; a line start fills every slot with the
  // first sample so ages beyond the line read the left edge
  logic [sfce_pkg::SAMPLE_BITS-1:0] win_d [sfce_pkg::WIN_DEPTH];
  logic [sfce_pkg::SAMPLE_BITS-1:0] win_q [sfce_pkg::WIN_DEPTH];
  // tap window: a copy that shifts older with the newest slot replicated,
  // putting the output centre on the middle cell
  logic [sfce_pkg::SAMPLE_BITS-1:0] x_d [sfce_pkg::WIN_DEPTH];
  logic [sfce_pkg::SAMPLE_BITS-1:0] x_q [sfce_pkg::WIN_DEPTH];

  always_comb begin
    for (int i = 0; i < sfce_pkg::WIN_DEPTH; i++) begin
      win_d[i] = win_q[i];
      x_d[i]   = x_q[i];
    end
    if (ctrl.accept) begin
      win_d[0] = s_axis_tdata;
      for (int i = 1; i < sfce_pkg::WIN_DEPTH; i++) begin
        win_d[i] = ctrl.line_start ? s_axis_tdata : win_q[i-1];
      end
      for (int i = 0; i < sfce_pkg::WIN_DEPTH; i++) begin
        x_d[i] = win_d[i];
      end
    end else if (ctrl.shift_x) begin
      for (int i = 1; i < sfce_pkg::WIN_DEPTH; i++) begin
        x_d[i] = x_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < sfce_pkg::WIN_DEPTH; i++) begin
      win_q[i] <= win_d[i];
      x_q[i]   <= x_d[i];
    end
  end

  // tap cell chain
  logic [sfce_pkg::ACC_W-1:0] acc [sfce_pkg::NTAPS];

  for (genvar k = 0; k < sfce_pkg::NTAPS; k++) begin : g_tap
    logic [sfce_pkg::COEF_W-1:0] coef_raw;
    logic [sfce_pkg::COEF_W-1:0] coef_eff;

    assign coef_raw = coef_q[k / sfce_pkg::COEFS_PER_REG]
                        [(k % sfce_pkg::COEFS_PER_REG) * sfce_pkg::COEF_W +: sfce_pkg::COEF_W];
    assign coef_eff = (sfce_pkg::SPAN_W'(k) <= span_eff) ? coef_raw : '0;

    if (k == 0) begin : g_head
      sfce_tap u_tap (
        .clk_i   (clk_i),
        .coef_i  (coef_eff),
        .newer_i (x_q[sfce_pkg::CENTER]),
        .older_i ('0),
        .acc_i   ('0),
        .acc_o   (acc[k])
      );
    end else begin : g_body
      sfce_tap u_tap (
        .clk_i   (clk_i),
        .coef_i  (coef_eff),
        .newer_i (x_q[sfce_pkg::CENTER-k]),
        .older_i (x_q[sfce_pkg::CENTER+k]),
        .acc_i   (acc[k-1]),
        .acc_o   (acc[k])
      );
    end
  end

  // round half up, then saturate
  logic [sfce_pkg::ACC_W-1:0]       rounded;
  logic [sfce_pkg::SCALED_W-1:0]    scaled;
  logic [sfce_pkg::SAMPLE_BITS-1:0] result;

  always_comb begin
    rounded = acc[sfce_pkg::NTAPS-1] + sfce_pkg::ROUND_HALF;
    scaled  = rounded[sfce_pkg::ACC_W-1:sfce_pkg::FRAC_BITS];
    result  = (scaled > sfce_pkg::SCALED_W'(sfce_pkg::SAMPLE_MAX))
            ? sfce_pkg::SAMPLE_MAX : scaled[sfce_pkg::SAMPLE_BITS-1:0];
  end

  // output register
  logic [sfce_pkg::SAMPLE_BITS-1:0] out_data_q;
  logic                             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_data_q <= result;
      out_last_q <= ctrl.out_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// File: hw/rtl/sfce_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfce_checker
// Port-level checks for the symmetric FIR clamp-to-edge unit.
// ----------------------------------------------------------------------------
module sfce_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               s_axis_tvalid,
  input wire logic                               s_axis_tready,
  input wire logic                               s_axis_tlast,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [sfce_pkg::SAMPLE_BITS-1:0]   m_axis_tdata,
  input wire logic                               m_axis_tlast
);

  logic s_beat;
  assign s_beat = s_axis_tvalid && s_axis_tready;

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // a line end always starts a flush, so the input side must close
  a_flush_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken during line-end flush");

  // a result needs the tap chain to settle; none can appear right after a beat
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat |=> !$rose(m_axis_tvalid))
    else $error("result appeared before tap chain settled");

endmodule

bind symmetric_fir_clamp_edge_unit sfce_checker u_sfce_checker (.*);
`default_nettype wire

// File: sim/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the symmetric FIR clamp-to-edge unit. Lines of Q8.8
// samples are streamed in under several tap settings. These include the reset
// pass-through, a full-scale saturating filter, mid-line span changes, short
// lines and lines longer than the position counter. A line-level predictor
// keeps its own sample window and registers. Each output beat is checked in
// order against it. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import sfce_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 25;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum int {COEF_SMOOTH, COEF_RANDOM, COEF_ZERO, COEF_FULL} coef_mode_e;

  class blur_line_scoreboard;
    typedef struct packed {
      logic [SAMPLE_BITS-1:0] filtered;
      logic                   line_last;
    } pixel_t;

    pixel_t                 expected_pixels[$];
    logic [SAMPLE_BITS-1:0] window[WIN_DEPTH];
    logic [SAMPLE_BITS-1:0] first_px;
    int unsigned            seen;
    int unsigned            span;
    logic [CFG_DATA_W-1:0]  coef_bank[COEF_REGS];
    int unsigned            errors;
    int unsigned            pixels_checked;

    function new();
      foreach (window[i]) window[i] = '0;
      first_px = '0;
      seen = 0;
      span = 0;
      coef_bank[0] = COEF0_RESET;
      coef_bank[1] = '0;
      coef_bank[2] = '0;
      coef_bank[3] = '0;
      errors = 0;
      pixels_checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TAP_SPAN: span = val[SPAN_W-1:0];
        REG_COEFS_0_3, REG_COEFS_4_7, REG_COEFS_8_11, REG_COEFS_12_15:
          coef_bank[2'(idx - REG_COEFS_0_3)] = val;
        default: ;
      endcase
    endfunction

    function logic [COEF_W-1:0] coef_of(int k);
      return coef_bank[2'(k / COEFS_PER_REG)][(k % COEFS_PER_REG) * COEF_W +: COEF_W];
    endfunction

    // ages past the start of the line read the first sample
    function logic [SAMPLE_BITS-1:0] px_at(int age);
      if (age >= int'(seen) || age >= WIN_DEPTH) return first_px;
      return window[age];
    endfunction

    function logic [SAMPLE_BITS-1:0] blur_at(int c);
      logic [63:0] acc;
      int          newer;
      int          k;
      acc = 64'(coef_of(0)) * 64'(px_at(c));
      for (k = 1; k <= int'(span); k++) begin
        newer = (k > c) ? 0 : c - k;
        acc += 64'(coef_of(k)) * (64'(px_at(newer)) + 64'(px_at(c + k)));
      end
      acc = (acc + 64'(ROUND_HALF)) >> FRAC_BITS;
      return (acc > 64'(SAMPLE_MAX)) ? SAMPLE_MAX : acc[SAMPLE_BITS-1:0];
    endfunction

    function void take_sample(logic [SAMPLE_BITS-1:0] px, logic eol);
      int pos;
      int c;
      int i;
      pos = int'(seen);
      if (pos == 0) first_px = px;
      for (i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = px;
      if (seen < POS_MAX) seen++;
      if (!eol) begin
        if (pos >= int'(span)) expected_pixels.push_back('{blur_at(int'(span)), 1'b0});
      end else begin
        // flush the rest of the line, oldest centre first
        c = (pos < int'(span)) ? pos : int'(span);
        for (i = c; i >= 0; i--) expected_pixels.push_back('{blur_at(i), i == 0});
        seen = 0;
      end
    endfunction

    task report(string what);
      $display("mismatch at output %0d: %s", pixels_checked, what);
      errors++;
    endtask

    task check_pixel(logic [SAMPLE_BITS-1:0] got, logic last);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("beat %h last=%b with nothing expected", got, last));
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want.filtered)
          report($sformatf("filtered %h, expected %h", got, want.filtered));
        if (last !== want.line_last)
          report($sformatf("line_last %b, expected %b", last, want.line_last));
      end
      pixels_checked++;
    endtask

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SAMPLE_BITS-1:0] s_axis_tdata = '0;   // [15:0] sample
  logic                   s_axis_tlast = 1'b0; // line_end
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [SAMPLE_BITS-1:0] m_axis_tdata;        // [15:0] filtered
  logic                   m_axis_tlast;        // line_last

  blur_line_scoreboard blur_sb = new();
  bit                  in_calm = 1'b0;
  int                  quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  symmetric_fir_clamp_edge_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d outputs outstanding",
               quiet_cycles, blur_sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output side: random stalls per beat, with runs of none
  initial begin
    int gap;
    bit calm;
    calm = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 9) == 0) calm = !calm;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      blur_sb.check_pixel(m_axis_tdata, m_axis_tlast);
    end
  end

  // leaves tvalid high; the caller drops it when the burst is over
  task send_sample(input logic [SAMPLE_BITS-1:0] px, input logic eol);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 9) == 0) in_calm = !in_calm;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tlast  <= eol;
    do @(posedge clk_i); while (!s_axis_tready);
    blur_sb.take_sample(px, eol);
  endtask

  // leaves cfg_valid_i high; the caller drops it after the last write
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    blur_sb.set_reg(idx, val);
  endtask

  task load_config(input int unsigned span, input logic [CFG_DATA_W-1:0] c0,
                   input logic [CFG_DATA_W-1:0] c1, input logic [CFG_DATA_W-1:0] c2,
                   input logic [CFG_DATA_W-1:0] c3, input bit poke_unmapped);
    write_reg(REG_TAP_SPAN, CFG_DATA_W'(span));
    if (poke_unmapped) write_reg(REG_UNMAPPED, {$urandom, $urandom});
    write_reg(REG_COEFS_0_3, c0);
    write_reg(REG_COEFS_4_7, c1);
    write_reg(REG_COEFS_8_11, c2);
    write_reg(REG_COEFS_12_15, c3);
    cfg_valid_i <= 1'b0;
  endtask

  // drain, then give the tap chain time to go idle
  task settle();
    while (blur_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_px();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] coef_word(coef_mode_e mode);
    logic [CFG_DATA_W-1:0] w;
    int i;
    for (i = 0; i < COEFS_PER_REG; i++) begin
      case (mode)
        COEF_SMOOTH: w[i*COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 16'h0C00));
        COEF_RANDOM: w[i*COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 65535));
        COEF_ZERO:   w[i*COEF_W +: COEF_W] = '0;
        default:     w[i*COEF_W +: COEF_W] = '1;
      endcase
    end
    return w;
  endfunction

  // mostly lines near the window size, some past the saturating counter
  function automatic int draw_line_len(int unsigned span);
    if ($urandom_range(0, 3) == 0) return $urandom_range(20, 45);
    return $urandom_range(1, 2 * span + 3);
  endfunction

  initial begin
    int unsigned span;
    coef_mode_e  mode;
    int          line_left;
    int          n;
    int          p;
    logic        eol;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: span 0, unity centre tap
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8001, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'hFF00, 1'b1);
    s_axis_tvalid <= 1'b0;
    settle();

    // widest span, all taps full scale: short lines, saturation
    load_config(MAX_SPAN, '1, '1, '1, '1, 1'b1);
    send_sample(16'h0001, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h1234, 1'b1);
    s_axis_tvalid <= 1'b0;
    settle();

    // span 2, then span 4 from the middle of the same line
    load_config(2, {16'h0400, 16'h0800, 16'h1000, 16'h2000}, 64'h0000_0000_0000_0200,
                '0, '0, 1'b0);
    send_sample(16'h1000, 1'b0);
    send_sample(16'hF000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h8000, 1'b0);
    s_axis_tvalid <= 1'b0;
    settle();
    write_reg(REG_TAP_SPAN, CFG_DATA_W'(4));
    cfg_valid_i <= 1'b0;
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h4321, 1'b0);
    send_sample(16'hABCD, 1'b1);

    // random phases; a line may run across a phase into a new setting
    line_left = 0;
    for (p = 0; p < RAND_PHASES; p++) begin
      s_axis_tvalid <= 1'b0;
      settle();
      span = (p == 0) ? MAX_SPAN : (p == 1) ? 0 : $urandom_range(0, MAX_SPAN);
      if (p < 4) mode = coef_mode_e'(p);
      else if ($urandom_range(0, 2) != 0) mode = COEF_SMOOTH;
      else mode = coef_mode_e'($urandom_range(0, 3));
      load_config(span, coef_word(mode), coef_word(mode), coef_word(mode), coef_word(mode),
                  $urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (line_left == 0) line_left = draw_line_len(span);
        line_left--;
        eol = (line_left == 0) || (p == RAND_PHASES - 1 && n == PHASE_ITEMS - 1);
        if (eol) line_left = 0;
        send_sample(rand_px(), eol);
      end
    end
    s_axis_tvalid <= 1'b0;
    settle();

    if (blur_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
hw/rtl/sfce_pkg.sv
hw/rtl/sfce_tap.sv
hw/rtl/sfce_ctrl.sv
hw/rtl/symmetric_fir_clamp_edge_unit.sv
hw/rtl/sfce_checker.sv
sim/tb.sv
